@@ rtl/local_label_binding_table_macros.svh @@
// Assertion macros for the local label binding table RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef LOCAL_LABEL_BINDING_TABLE_MACROS_SVH
`define LOCAL_LABEL_BINDING_TABLE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted
`define LBT_ASSERT_IMPLIES(name, clk_sig, rstn_sig, ante, cons, msg) \
    name: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define LBT_ASSERT_NEXT(name, clk_sig, rstn_sig, ante, cons, msg) \
    name: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |=> (cons)) \
        else $error(msg);

`else

`define LBT_ASSERT_IMPLIES(name, clk_sig, rstn_sig, ante, cons, msg)
`define LBT_ASSERT_NEXT(name, clk_sig, rstn_sig, ante, cons, msg)

`endif

`endif

@@ rtl/lbt_pkg.sv @@
// Shared types and constants for the local label binding table.
// No dependencies; imported by every module of the block.
`default_nettype none

package lbt_pkg;

    // Field widths
    localparam int LABEL_W   = 20;
    localparam int PREFIX_W  = 32;
    localparam int PLEN_W    = 6;
    localparam int OP_W      = 2;
    localparam int STATUS_W  = 2;
    localparam int NEXT_W    = LABEL_W + 1;

    // Stream and register port widths
    localparam int S_TDATA_W  = 64;
    localparam int S_TUSER_W  = OP_W;
    localparam int M_TDATA_W  = 24;
    localparam int M_TUSER_W  = STATUS_W + 1;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Defaults
    localparam int TABLE_ENTRIES_DEF = 256;
    localparam logic [LABEL_W-1:0] FIRST_LABEL_RST = 20'd16;
    localparam logic [LABEL_W-1:0] LAST_LABEL_RST  = 20'hFFFFF;

    // Register index (taken from paddr[2])
    localparam logic CFG_IDX_FIRST = 1'b0;
    localparam logic CFG_IDX_LAST  = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC  = 2'd0,
        OP_SET    = 2'd1,
        OP_FREE   = 2'd2,
        OP_LOOKUP = 2'd3
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NEW       = 2'd1,
        ST_EXHAUSTED = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    // One table slot as stored in memory
    typedef struct packed {
        logic                valid;
        logic [PREFIX_W-1:0] prefix;
        logic [PLEN_W-1:0]   plen;
        logic [LABEL_W-1:0]  label;
    } entry_t;

    // Scan outcome flags from the compare unit
    typedef struct packed {
        logic found;
        logic free_found;
    } scan_flags_t;

endpackage

`default_nettype wire

@@ rtl/local_label_binding_table.sv @@
// Local label binding table: top level with sequencer, config registers and
// output register. Depends on lbt_pkg, lbt_mem, lbt_cmp and the macro header.
//
//  Channel  | Dir | Handshake          | Payload
//  ---------+-----+--------------------+----------------------------------------
//  s_*      | in  | s_tvalid/s_tready  | tdata: prefix, prefix_length, new_label
//           |     |                    | tuser: opcode
//  m_*      | out | m_tvalid/m_tready  | tdata: label; tuser: hit, status
//  APB      | in  | psel/penable       | 0x0 first_label, 0x4 last_label
//
//  After reset a clearing pass writes every slot invalid, with s_tready
//  low throughout (register writes still taken).
//  Each operation, from accept to the next ready, scans the table memory,
//  one read per cycle through the compare unit, then passes a drain state
//  and an execute state that writes back.
//  A result waits in the output register; a stalled m_tready holds the
//  execute step of the following operation only.
`default_nettype none
`include "local_label_binding_table_macros.svh"

module local_label_binding_table
    import lbt_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // Input stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,  // [31:0] prefix, [37:32] prefix_length,
                                                 // [57:38] new_label, [63:58] zero
    input  wire logic [S_TUSER_W-1:0]  s_tuser,  // [1:0] opcode
    // Result stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata,  // [19:0] label, [23:20] zero
    output logic [M_TUSER_W-1:0]       m_tuser,  // [0] hit, [2:1] status
    // Register port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0]      prdata,
    output logic                       pready
);

    localparam int ADDR_W = $clog2(TABLE_ENTRIES);
    localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(TABLE_ENTRIES - 1);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_SCAN  = 5'b00100,
        S_DRAIN = 5'b01000,
        S_EXEC  = 5'b10000
    } state_t;

    state_t               state_reg, state_next;
    logic [ADDR_W-1:0]    cnt_reg, cnt_next;
    logic                 rd_vld_reg;
    logic [ADDR_W-1:0]    rd_idx_reg;
    opcode_t              op_reg;
    logic [PREFIX_W-1:0]  prefix_reg;
    logic [PLEN_W-1:0]    plen_reg;
    logic [LABEL_W-1:0]   nlabel_reg;
    logic [LABEL_W-1:0]   first_label_reg;
    logic [LABEL_W-1:0]   last_label_reg;
    logic [NEXT_W-1:0]    next_free_reg;
    logic                 m_tvalid_reg;
    logic [LABEL_W-1:0]   m_label_reg;
    logic                 m_hit_reg;
    status_t              m_status_reg;

    logic                 in_beat;
    logic                 cfg_wr;
    logic                 out_free;
    logic                 exec_fire;
    logic                 mem_re;
    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_waddr;
    entry_t               mem_wdata;
    entry_t               rd_entry;
    scan_flags_t          scan;
    logic [ADDR_W-1:0]    hit_idx;
    logic [LABEL_W-1:0]   hit_label;
    logic [ADDR_W-1:0]    free_idx;

    logic                 res_hit;
    logic [LABEL_W-1:0]   res_label;
    status_t              res_status;
    logic                 ex_we;
    logic [ADDR_W-1:0]    ex_addr;
    entry_t               ex_entry;
    logic                 alloc_adv;

    assign in_beat   = s_tvalid && s_tready;
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign exec_fire = (state_reg == S_EXEC) && out_free;
    assign s_tready  = (state_reg == S_IDLE);

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_IDX)
                begin
                    state_next = S_IDLE;
                    cnt_next   = '0;
                end
            end
            S_IDLE:
            begin
                if (in_beat)
                begin
                    state_next = S_SCAN;
                    cnt_next   = '0;
                end
            end
            S_SCAN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_IDX)
                begin
                    state_next = S_DRAIN;
                    cnt_next   = '0;
                end
            end
            S_DRAIN:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            cnt_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            rd_vld_reg <= mem_re;
        end
    end

    // Read index follows the registered memory read
    always_ff @(posedge clk)
    begin
        rd_idx_reg <= cnt_reg;
    end

    // Item capture
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            op_reg     <= opcode_t'(s_tuser[OP_W-1:0]);
            prefix_reg <= s_tdata[PREFIX_W-1:0];
            plen_reg   <= s_tdata[PREFIX_W +: PLEN_W];
            nlabel_reg <= s_tdata[PREFIX_W + PLEN_W +: LABEL_W];
        end
    end

    // Operation decode on the scan outcome
    always_comb
    begin
        res_hit    = scan.found;
        res_label  = '0;
        res_status = ST_OK;
        ex_we      = 1'b0;
        ex_addr    = hit_idx;
        ex_entry   = '{valid: 1'b1, prefix: prefix_reg, plen: plen_reg, label: nlabel_reg};
        alloc_adv  = 1'b0;
        if (scan.found)
        begin
            res_label = hit_label;
            unique case (op_reg)
                OP_SET:
                begin
                    res_label = nlabel_reg;
                    ex_we     = 1'b1;
                end
                OP_FREE:
                begin
                    ex_we          = 1'b1;
                    ex_entry.valid = 1'b0;
                    ex_entry.label = hit_label;
                end
                default:
                begin
                    ex_we = 1'b0;
                end
            endcase
        end
        else if ((op_reg == OP_ALLOC) || (op_reg == OP_SET))
        begin
            if ((op_reg == OP_ALLOC) && (next_free_reg > {1'b0, last_label_reg}))
            begin
                res_status = ST_EXHAUSTED;
            end
            else if (!scan.free_found)
            begin
                res_status = ST_FULL;
            end
            else
            begin
                res_label      = (op_reg == OP_ALLOC) ? next_free_reg[LABEL_W-1:0]
                                                      : nlabel_reg;
                ex_we          = 1'b1;
                ex_addr        = free_idx;
                ex_entry.label = res_label;
                alloc_adv      = (op_reg == OP_ALLOC);
                res_status     = ST_NEW;
            end
        end
    end

    // Memory port mux: clearing pass or write-back
    assign mem_re    = (state_reg == S_SCAN);
    assign mem_we    = (state_reg == S_CLEAR) || (exec_fire && ex_we);
    assign mem_waddr = (state_reg == S_CLEAR) ? cnt_reg : ex_addr;
    assign mem_wdata = (state_reg == S_CLEAR) ? entry_t'('0) : ex_entry;

    lbt_mem #(
        .DEPTH  (TABLE_ENTRIES),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (cnt_reg),
        .rdata (rd_entry)
    );

    lbt_cmp #(
        .ADDR_W (ADDR_W)
    ) u_cmp (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (in_beat),
        .rd_vld     (rd_vld_reg),
        .rd_idx     (rd_idx_reg),
        .rd_entry   (rd_entry),
        .key_prefix (prefix_reg),
        .key_plen   (plen_reg),
        .flags      (scan),
        .hit_idx    (hit_idx),
        .hit_label  (hit_label),
        .free_idx   (free_idx)
    );

    // Config registers and allocation counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_label_reg <= FIRST_LABEL_RST;
            last_label_reg  <= LAST_LABEL_RST;
            next_free_reg   <= {1'b0, FIRST_LABEL_RST};
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == CFG_IDX_FIRST)
            begin
                first_label_reg <= pwdata[LABEL_W-1:0];
                next_free_reg   <= {1'b0, pwdata[LABEL_W-1:0]};
            end
            else
            begin
                last_label_reg <= pwdata[LABEL_W-1:0];
            end
        end
        else if (exec_fire && alloc_adv)
        begin
            next_free_reg <= next_free_reg + 1'b1;
        end
    end

    // Register read-back
    always_comb
    begin
        unique case (paddr[2])
            CFG_IDX_FIRST: prdata = {{(APB_DATA_W - LABEL_W){1'b0}}, first_label_reg};
            default:       prdata = {{(APB_DATA_W - LABEL_W){1'b0}}, last_label_reg};
        endcase
    end

    assign pready = 1'b1;

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (exec_fire)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec_fire)
        begin
            m_label_reg  <= res_label;
            m_hit_reg    <= res_hit;
            m_status_reg <= res_status;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W - LABEL_W){1'b0}}, m_label_reg};
    assign m_tuser  = {m_status_reg, m_hit_reg};

    // Checks
    `LBT_ASSERT_NEXT(a_accept_starts_scan, clk, rst_n, in_beat,
        (state_reg == S_SCAN) && (cnt_reg == '0), "accepted beat did not start a scan")
    `LBT_ASSERT_IMPLIES(a_new_not_hit, clk, rst_n,
        m_tvalid_reg && (m_status_reg == ST_NEW), !m_hit_reg,
        "newly inserted result reports a hit")
    `LBT_ASSERT_IMPLIES(a_fail_label_zero, clk, rst_n,
        m_tvalid_reg && ((m_status_reg == ST_EXHAUSTED) || (m_status_reg == ST_FULL)),
        (m_label_reg == '0) && !m_hit_reg, "failed insert carries a label or hit")
    `LBT_ASSERT_NEXT(a_counter_monotonic, clk, rst_n, !cfg_wr,
        next_free_reg >= $past(next_free_reg), "allocation counter moved backward")

endmodule

`default_nettype wire

@@ rtl/lbt_mem.sv @@
// Binding table storage: one write port, one registered read port.
// Depends on lbt_pkg for the slot layout.
`default_nettype none

module lbt_mem
    import lbt_pkg::*;
#(
    parameter int DEPTH  = TABLE_ENTRIES_DEF,
    parameter int ADDR_W = $clog2(TABLE_ENTRIES_DEF)
)
(
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire entry_t            wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output entry_t                 rdata
);

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ rtl/lbt_cmp.sv @@
// Shared compare unit: checks one slot a cycle against the key and keeps
// the first matching slot and the first free slot. Depends on lbt_pkg.
`default_nettype none

module lbt_cmp
    import lbt_pkg::*;
#(
    parameter int ADDR_W = $clog2(TABLE_ENTRIES_DEF)
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic                rd_vld,
    input  wire logic [ADDR_W-1:0]   rd_idx,
    input  wire entry_t              rd_entry,
    input  wire logic [PREFIX_W-1:0] key_prefix,
    input  wire logic [PLEN_W-1:0]   key_plen,
    output scan_flags_t              flags,
    output logic [ADDR_W-1:0]        hit_idx,
    output logic [LABEL_W-1:0]       hit_label,
    output logic [ADDR_W-1:0]        free_idx
);

    logic               found_reg;
    logic               free_reg;
    logic [ADDR_W-1:0]  hit_idx_reg;
    logic [LABEL_W-1:0] hit_label_reg;
    logic [ADDR_W-1:0]  free_idx_reg;
    logic               match;
    logic               empty;

    // Slot classification
    assign match = rd_entry.valid && (rd_entry.prefix == key_prefix)
                   && (rd_entry.plen == key_plen);
    assign empty = !rd_entry.valid;

    // Flags: cleared on start, set on first occurrence
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
            free_reg  <= 1'b0;
        end
        else if (start)
        begin
            found_reg <= 1'b0;
            free_reg  <= 1'b0;
        end
        else if (rd_vld)
        begin
            if (match)
            begin
                found_reg <= 1'b1;
            end
            if (empty)
            begin
                free_reg <= 1'b1;
            end
        end
    end

    // Captured slot indexes and label
    always_ff @(posedge clk)
    begin
        if (rd_vld && !start)
        begin
            if (match && !found_reg)
            begin
                hit_idx_reg   <= rd_idx;
                hit_label_reg <= rd_entry.label;
            end
            if (empty && !free_reg)
            begin
                free_idx_reg <= rd_idx;
            end
        end
    end

    assign flags.found      = found_reg;
    assign flags.free_found = free_reg;
    assign hit_idx          = hit_idx_reg;
    assign hit_label        = hit_label_reg;
    assign free_idx         = free_idx_reg;

endmodule

`default_nettype wire
